/* design/prb_pkg.sv */
// shared types and codes for the packet ring buffer
package prb_pkg;

   typedef enum logic [2:0] {
      KIND_WRITE_START = 3'd0,
      KIND_WRITE_BYTE  = 3'd1,
      KIND_READ_START  = 3'd2,
      KIND_READ_BYTE   = 3'd3,
      KIND_SKIP        = 3'd4,
      KIND_RESET       = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_TOO_SMALL = 3'd3,
      ST_ZERO_LEN  = 3'd4,
      ST_SEQUENCE  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_HDR_WRITE,
      S_HDR_READ,
      S_HDR_WAIT,
      S_DATA_READ,
      S_DATA_WAIT,
      S_FINISH,
      S_RESPOND
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_HDR_WR,
      OP_HDR_RD,
      OP_HDR_CAP,
      OP_DATA_WR,
      OP_DATA_RD,
      OP_DATA_CAP,
      OP_FIN_WSTART,
      OP_FIN_RSTART,
      OP_FIN_SKIP,
      OP_FIN_STATUS,
      OP_FIN_RESET
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type fin_status;
   } cmd_type;

   typedef struct packed {
      logic       write_open;
      logic       read_open;
      logic       have_packet;
      logic       fits;
      logic       zero_len;
      logic       cap_small;
      logic       hdr_done;
      kind_type   kind;
   } stat_type;

endpackage

/* design/packet_ring_buffer.sv */
// top level of the packet ring buffer
// Circular byte store of timestamped packets, one transaction in and one
// response out per request, one request at a time. Header bytes move one at
// a time, and each header read waits for the registered store output. Ring
// size writes empty the ring.
`default_nettype none
module packet_ring_buffer
   import prb_pkg::*;
#(
   parameter int STORE_BYTES  = 65536,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write,
   input  wire logic [16:0]  csr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [2:0]   req_kind,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic [15:0]  req_length,
   input  wire logic [63:0]  req_timestamp,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [15:0]       rsp_packet_length,
   output logic [63:0]       rsp_packet_time,
   output logic [16:0]       rsp_packets_held,
   output logic [15:0]       rsp_free_bytes,
   output logic [31:0]       rsp_dropped_total,
   output logic [31:0]       rsp_written_total
);

   cmd_type  cmd;
   stat_type stat;
   logic     busy;

   assign req_ready = !busy;

   prb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_valid), .rsp_taken(rsp_ready),
      .stat(stat), .cmd(cmd), .busy(busy), .rsp_hold(rsp_valid)
   );

   prb_datapath #(.STORE_BYTES(STORE_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .csr_write(csr_write),
      .csr_data(csr_data), .req_kind(req_kind), .req_data_byte(req_data_byte),
      .req_length(req_length), .req_timestamp(req_timestamp), .stat(stat),
      .rsp_status(rsp_status), .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last),
      .rsp_packet_length(rsp_packet_length), .rsp_packet_time(rsp_packet_time),
      .rsp_packets_held(rsp_packets_held), .rsp_free_bytes(rsp_free_bytes),
      .rsp_dropped_total(rsp_dropped_total), .rsp_written_total(rsp_written_total)
   );

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("accepted twice");
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_dropped_total != $past(rsp_dropped_total)) |-> rsp_status == ST_NO_SPACE
      || $past(reset)) else $error("drop count moved without drop");

endmodule
`default_nettype wire

/* design/prb_ctrl.sv */
// controller state machine of the packet ring buffer
`default_nettype none
module prb_ctrl
   import prb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     rsp_taken,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy,
   output logic          rsp_hold
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      cmd.fin_status = ST_OK;
      busy = 1'b1;
      rsp_hold = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESPOND;
            cmd.op = OP_FIN_STATUS;
            case (stat.kind)
               KIND_WRITE_START: begin
                  if (stat.write_open) begin
                     cmd.fin_status = ST_SEQUENCE;
                  end else if (stat.zero_len) begin
                     cmd.fin_status = ST_ZERO_LEN;
                  end else if (!stat.fits) begin
                     cmd.fin_status = ST_NO_SPACE;
                  end else begin
                     cmd.op = OP_CHECK;
                     state_in = S_HDR_WRITE;
                  end
               end
               KIND_WRITE_BYTE: begin
                  if (!stat.write_open) begin
                     cmd.fin_status = ST_SEQUENCE;
                  end else begin
                     cmd.op = OP_DATA_WR;
                  end
               end
               KIND_READ_START, KIND_SKIP: begin
                  if (stat.read_open) begin
                     cmd.fin_status = ST_SEQUENCE;
                  end else if (!stat.have_packet) begin
                     cmd.fin_status = ST_EMPTY;
                  end else begin
                     cmd.op = OP_CHECK;
                     state_in = S_HDR_READ;
                  end
               end
               KIND_READ_BYTE: begin
                  if (!stat.read_open) begin
                     cmd.fin_status = ST_SEQUENCE;
                  end else begin
                     cmd.op = OP_DATA_RD;
                     state_in = S_DATA_WAIT;
                  end
               end
               KIND_RESET: begin
                  cmd.op = OP_FIN_RESET;
               end
               default: begin
                  cmd.fin_status = ST_SEQUENCE;
               end
            endcase
         end
         S_HDR_WRITE: begin
            cmd.op = OP_HDR_WR;
            if (stat.hdr_done) begin
               state_in = S_FINISH;
            end
         end
         S_HDR_READ: begin
            cmd.op = OP_HDR_RD;
            state_in = S_HDR_WAIT;
         end
         S_HDR_WAIT: begin
            cmd.op = OP_HDR_CAP;
            state_in = stat.hdr_done ? S_FINISH : S_HDR_READ;
         end
         S_DATA_WAIT: begin
            cmd.op = OP_DATA_CAP;
            state_in = S_RESPOND;
         end
         S_FINISH: begin
            state_in = S_RESPOND;
            if (stat.kind == KIND_WRITE_START) begin
               cmd.op = OP_FIN_WSTART;
            end else if (stat.kind == KIND_SKIP) begin
               cmd.op = OP_FIN_SKIP;
            end else if (stat.kind == KIND_READ_START) begin
               cmd.op = OP_FIN_RSTART;
            end
         end
         S_RESPOND: begin
            rsp_hold = 1'b1;
            if (rsp_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* design/prb_datapath.sv */
// pointers, counters, header handling and byte store of the packet ring buffer
`default_nettype none
module prb_datapath
   import prb_pkg::*;
#(
   parameter int STORE_BYTES  = 65536,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic         csr_write,
   input  wire logic [16:0]  csr_data,
   input  wire logic [2:0]   req_kind,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic [15:0]  req_length,
   input  wire logic [63:0]  req_timestamp,
   output stat_type          stat,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [15:0]       rsp_packet_length,
   output logic [63:0]       rsp_packet_time,
   output logic [16:0]       rsp_packets_held,
   output logic [15:0]       rsp_free_bytes,
   output logic [31:0]       rsp_dropped_total,
   output logic [31:0]       rsp_written_total
);

   localparam int TOP = (STORE_BYTES < 65536) ? STORE_BYTES : 65536;
   localparam int AW = $clog2(TOP);
   localparam int HW = $clog2(HEADER_BYTES + 1);
   localparam logic [16:0] TOP17 = 17'(TOP);
   localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);

   logic [7:0] mem [TOP];
   logic [7:0] rd_data_ff;

   logic [16:0] size_ff, size_in;
   logic [15:0] wp_ff, rp_ff, wrem_ff, rrem_ff;
   logic [16:0] pcnt_ff;
   logic        full_ff;
   logic [31:0] drop_ff, commit_ff;
   logic [2:0]  kind_ff;
   logic [7:0]  dbyte_ff;
   logic [15:0] len_ff;
   logic [63:0] ts_ff;
   logic [16:0] avail_ff;
   logic [HW-1:0] hidx_ff;
   logic [15:0] hlen_ff;
   logic [63:0] htime_ff;
   logic [16:0] hptr_ff;
   logic [15:0] tp_ff;

   logic [16:0] used, avail, req17, hwrap, sum_hl;
   logic        wr_en;
   logic [15:0] wr_addr, rd_addr;
   logic [7:0]  wr_byte, hbyte;

   function automatic logic [15:0] wrap1(input logic [16:0] p, input logic [16:0] s);
      logic [16:0] r;
      r = (p >= s) ? p - s : p;
      return r[15:0];
   endfunction

   always_comb begin
      size_in = csr_data;
      if (size_in < 17'd64) size_in = 17'd64;
      if (size_in > TOP17) size_in = TOP17;
   end

   always_comb begin
      if (wp_ff >= rp_ff) used = {1'b0, wp_ff} - {1'b0, rp_ff};
      else used = size_ff - {1'b0, rp_ff} + {1'b0, wp_ff};
      if (full_ff || used + 17'd1 > size_ff) avail = '0;
      else avail = size_ff - used - 17'd1;
   end

   assign req17 = HDR17 + {1'b0, len_ff};
   assign sum_hl = {1'b0, rp_ff} + HDR17 + {1'b0, hlen_ff};
   assign hwrap = {1'b0, wrap1(hptr_ff, size_ff)};

   always_comb begin
      stat.write_open = wrem_ff != '0;
      stat.read_open = rrem_ff != '0;
      stat.have_packet = pcnt_ff != '0;
      stat.fits = req17 <= avail_ff;
      stat.zero_len = len_ff == '0;
      stat.cap_small = len_ff < hlen_ff;
      stat.hdr_done = hidx_ff == HW'(HEADER_BYTES - 1);
      stat.kind = kind_type'(kind_ff);
   end

   always_comb begin
      if (hidx_ff < HW'(2)) hbyte = len_ff[8*hidx_ff[0] +: 8];
      else if (hidx_ff < HW'(10)) hbyte = ts_ff[8*(3'(hidx_ff - HW'(2))) +: 8];
      else hbyte = '0;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = hwrap[15:0];
      wr_byte = hbyte;
      rd_addr = hwrap[15:0];
      if (cmd.op == OP_HDR_WR) begin
         wr_en = 1'b1;
      end else if (cmd.op == OP_DATA_WR) begin
         wr_en = 1'b1;
         wr_addr = wp_ff;
         wr_byte = dbyte_ff;
      end
      if (cmd.op == OP_DATA_RD) rd_addr = rp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[AW-1:0]] <= wr_byte;
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      avail_ff <= avail;
      if (cmd.op == OP_LOAD) begin
         kind_ff <= req_kind;
         dbyte_ff <= req_data_byte;
         len_ff <= req_length;
         ts_ff <= req_timestamp;
         rsp_out_byte <= '0;
         rsp_last <= 1'b0;
         rsp_packet_length <= '0;
         rsp_packet_time <= '0;
         rsp_status <= ST_OK;
         hidx_ff <= '0;
      end
      if (cmd.op == OP_CHECK) begin
         hidx_ff <= '0;
         hptr_ff <= {1'b0, kind_ff == KIND_WRITE_START ? wp_ff : rp_ff};
         hlen_ff <= '0;
         htime_ff <= '0;
      end
      if (cmd.op == OP_HDR_WR) begin
         hidx_ff <= hidx_ff + HW'(1);
         hptr_ff <= hwrap + 17'd1;
      end
      if (cmd.op == OP_HDR_RD) begin
         hptr_ff <= hwrap + 17'd1;
      end
      if (cmd.op == OP_HDR_CAP) begin
         if (hidx_ff < HW'(2)) hlen_ff[8*hidx_ff[0] +: 8] <= rd_data_ff;
         else if (hidx_ff < HW'(10))
            htime_ff[8*(3'(hidx_ff - HW'(2))) +: 8] <= rd_data_ff;
         if (!stat.hdr_done) hidx_ff <= hidx_ff + HW'(1);
      end
      if (cmd.op == OP_FIN_STATUS) rsp_status <= cmd.fin_status;
      if (cmd.op == OP_DATA_WR) rsp_last <= wrem_ff == 16'd1;
      if (cmd.op == OP_DATA_CAP) begin
         rsp_out_byte <= rd_data_ff;
         rsp_last <= rrem_ff == 16'd0;
      end
      if (cmd.op == OP_FIN_RSTART || cmd.op == OP_FIN_SKIP) begin
         rsp_packet_length <= hlen_ff;
         rsp_packet_time <= htime_ff;
         if (cmd.op == OP_FIN_RSTART && stat.cap_small) rsp_status <= ST_TOO_SMALL;
      end
      tp_ff <= wrap1(sum_hl, size_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= TOP17;
         wp_ff <= '0; rp_ff <= '0; wrem_ff <= '0; rrem_ff <= '0;
         pcnt_ff <= '0; full_ff <= 1'b0; drop_ff <= '0; commit_ff <= '0;
      end else if (csr_write || cmd.op == OP_FIN_RESET) begin
         if (csr_write) size_ff <= size_in;
         wp_ff <= '0; rp_ff <= '0; wrem_ff <= '0; rrem_ff <= '0;
         pcnt_ff <= '0; full_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_FIN_STATUS: begin
               if (cmd.fin_status == ST_NO_SPACE) drop_ff <= drop_ff + 32'd1;
            end
            OP_FIN_WSTART: begin
               wp_ff <= hwrap[15:0];
               wrem_ff <= len_ff;
            end
            OP_DATA_WR: begin
               wp_ff <= wrap1({1'b0, wp_ff} + 17'd1, size_ff);
               wrem_ff <= wrem_ff - 16'd1;
               if (wrem_ff == 16'd1) begin
                  pcnt_ff <= pcnt_ff + 17'd1;
                  commit_ff <= commit_ff + 32'd1;
                  if (wrap1({1'b0, wp_ff} + 17'd1, size_ff) == rp_ff) full_ff <= 1'b1;
               end
            end
            OP_DATA_RD: begin
               rp_ff <= wrap1({1'b0, rp_ff} + 17'd1, size_ff);
               rrem_ff <= rrem_ff - 16'd1;
            end
            OP_FIN_RSTART: begin
               if (!stat.cap_small) begin
                  rp_ff <= hwrap[15:0];
                  rrem_ff <= hlen_ff;
                  pcnt_ff <= pcnt_ff - 17'd1;
                  full_ff <= 1'b0;
               end
            end
            OP_FIN_SKIP: begin
               rp_ff <= tp_ff;
               pcnt_ff <= pcnt_ff - 17'd1;
               full_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_packets_held = pcnt_ff;
   assign rsp_dropped_total = drop_ff;
   assign rsp_written_total = commit_ff;
   assign rsp_free_bytes = (avail >= {1'b0, wrem_ff}) ? 16'(avail - {1'b0, wrem_ff}) : '0;

endmodule
`default_nettype wire
